// ===== rtl/gqa_pkg.sv =====
// ----------------------------------------------------------------------------
// gqa_pkg
// Shared types, codes and constants for the decode-step attention block.
// ----------------------------------------------------------------------------
package gqa_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_WR_Q = 2'd0,
    OP_WR_K = 2'd1,
    OP_WR_V = 2'd2,
    OP_RUN  = 2'd3
  } gqa_op_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCORE,
    S_SCORE_W,
    S_NORM,
    S_NORM_W,
    S_OUT,
    S_OUT_W
  } gqa_state_e;

  // Register indexes on the configuration port
  localparam logic REG_NORM_MODE   = 1'b0;
  localparam logic REG_SCORE_SCALE = 1'b1;

  // Fixed arithmetic constants
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [31:0] STEP_Q32  = 32'd4283353945;
  localparam int          NSAT_W    = 21;  // distance beyond this always gives zero weight
  localparam int          QUO_W     = 17;
  localparam int          EXP_I_MAX = 17;

  // Controller to datapath commands
  typedef struct packed {
    logic load_q;
    logic load_k;
    logic load_v;
    logic score;
    logic norm;
    logic out;
    logic first;
    logic last;
    logic tail;
  } gqa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic score_done;
    logic norm_done;
    logic elem_done;
  } gqa_sts_t;

  typedef logic [255:0][16:0] exp_tab_t;

  // Build the 2^(-f/256) table in Q1.16 by a Q.32 recurrence
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [95:0] a;
    a = 96'd1 << 32;
    for (int f = 0; f < 256; f++) begin
      tab[f] = 17'((a + 96'd32768) >> 16);
      a = ((a * 96'(STEP_Q32)) + (96'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // Clamp a signed magnitude to the int16 range
  function automatic logic [15:0] clamp_q8(input logic neg, input logic [QUO_W-1:0] q);
    logic [15:0] r;
    if (neg) begin
      r = (q > 17'd32768) ? 16'h8000 : 16'((~q) + 17'd1);
    end else begin
      r = (q > 17'd32767) ? 16'h7fff : q[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/gqa_div.sv =====
// ----------------------------------------------------------------------------
// gqa_div
// Restoring divider, one quotient bit per cycle, 17-bit saturating quotient.
// ----------------------------------------------------------------------------
module gqa_div import gqa_pkg::*; #(
  parameter int NW   = 64,
  parameter int DENW = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DENW-1:0]  den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CW = (NW > DENW + QUO_W) ? NW : DENW + QUO_W;

  logic             busy_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [CW-1:0]    rem_q;
  logic [CW-1:0]    dsr_q;
  logic [QUO_W-1:0] quo_q;
  logic             sat;
  logic             fits;

  assign sat  = CW'(num_i) >= (CW'(den_i) << QUO_W);
  assign fits = rem_q >= dsr_q;

  // Sequence the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !sat;
        done_q <= sat;
        cnt_q  <= 5'(QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CW'(num_i);
      dsr_q <= CW'(den_i) << (QUO_W - 1);
      quo_q <= sat ? '1 : '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsr_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], fits};
      dsr_q <= dsr_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/gqa_dpath.sv =====
// ----------------------------------------------------------------------------
// gqa_dpath
// Stores, multiply-accumulate pipeline, exponent stage and output divider.
// ----------------------------------------------------------------------------
module gqa_dpath import gqa_pkg::*; #(
  parameter int CTX          = 64,
  parameter int NUM_HEADS    = 8,
  parameter int NUM_KV_HEADS = 2,
  parameter int VEC_LEN      = 64,
  parameter int PW           = 6,
  parameter int DW           = 6,
  parameter int KVW          = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gqa_cmd_t           cmd_i,
  input  logic [2:0]         head_i,
  input  logic [5:0]         position_i,
  input  logic [5:0]         dim_i,
  input  logic signed [15:0] value_i,
  input  logic [2:0]         rhead_i,
  input  logic [KVW-1:0]     kvh_i,
  input  logic [PW-1:0]      pos_i,
  input  logic [DW-1:0]      rdim_i,
  input  logic               norm_mode_i,
  input  logic [15:0]        score_scale_i,
  output gqa_sts_t           sts_o,
  output logic               res_vld_o,
  output logic [15:0]        res_val_o
);

  localparam int QD    = NUM_HEADS * VEC_LEN;
  localparam int KD    = CTX * NUM_KV_HEADS * VEC_LEN;
  localparam int QAW   = (QD > 1) ? $clog2(QD) : 1;
  localparam int KAW   = (KD > 1) ? $clog2(KD) : 1;
  localparam int DOT_W = 33 + $clog2(VEC_LEN);
  localparam int N_W   = DOT_W + 1;
  localparam int SP_W  = DOT_W + 17;
  localparam int MP_W  = DOT_W + 16;
  localparam int ACC_W = MP_W + $clog2(CTX) + 1;
  localparam int QN_W  = ACC_W - 15;
  localparam int TW    = 18 + $clog2(CTX);
  localparam int NUMW  = ACC_W + 1;
  localparam int M_W   = NSAT_W + 17;

  // Stores
  logic signed [15:0]      qmem [QD];
  logic signed [15:0]      kmem [KD];
  logic signed [15:0]      vmem [KD];
  logic signed [DOT_W-1:0] wmem [CTX];

  logic [QAW-1:0] q_wa, q_ra;
  logic [KAW-1:0] kv_wa, kv_ra;
  logic signed [15:0]      q_rd_q, k_rd_q, v_rd_q;
  logic signed [DOT_W-1:0] w_rd_q;

  // Pipeline tags
  logic s1_score_q, s1_norm_q, s1_out_q, s1_first_q, s1_last_q, s1_tail_q;
  logic s2_score_q, s2_norm_q, s2_out_q, s2_first_q, s2_last_q, s2_tail_q;
  logic [PW-1:0] s1_pos_q, s2_pos_q, s3_pos_q, s4_pos_q;
  logic s3_vld_q, s3_tail_q, s4_vld_q, s4_tail_q, fin_q;

  // Arithmetic registers
  logic signed [31:0]      prod_q;
  logic signed [MP_W-1:0]  mprod_q;
  logic [M_W-1:0]          m_q;
  logic signed [DOT_W-1:0] dot_q;
  logic signed [SP_W-1:0]  sprod_q;
  logic signed [DOT_W-1:0] max_q;
  logic [TW-1:0]           total_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    fneg_q;
  logic                    res_vld_q;
  logic [15:0]             res_val_q;

  logic signed [N_W-1:0]   n_w;
  logic [NSAT_W-1:0]       nsat;
  logic [5:0]              exp_i;
  logic [7:0]              exp_f;
  logic [16:0]             wexp;
  logic signed [DOT_W-1:0] score;
  logic                    w_we;
  logic [PW-1:0]           w_wa;
  logic signed [DOT_W-1:0] w_wd;
  logic [ACC_W-1:0]        mag;
  logic [QN_W-1:0]         qn;
  logic [QUO_W-1:0]        q_raw;
  logic                    div_start;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;

  // Form store addresses
  assign q_wa  = QAW'(int'(head_i) * VEC_LEN + int'(dim_i));
  assign q_ra  = QAW'(int'(rhead_i) * VEC_LEN + int'(rdim_i));
  assign kv_wa = KAW'((int'(position_i) * NUM_KV_HEADS + int'(head_i)) * VEC_LEN
                      + int'(dim_i));
  assign kv_ra = KAW'((int'(pos_i) * NUM_KV_HEADS + int'(kvh_i)) * VEC_LEN
                      + int'(rdim_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_q) begin
      qmem[q_wa] <= value_i;
    end
    q_rd_q <= qmem[q_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_k) begin
      kmem[kv_wa] <= value_i;
    end
    k_rd_q <= kmem[kv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_v) begin
      vmem[kv_wa] <= value_i;
    end
    v_rd_q <= vmem[kv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_wa] <= w_wd;
    end
    w_rd_q <= wmem[pos_i];
  end

  // Advance pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_score_q <= 1'b0;
      s1_norm_q  <= 1'b0;
      s1_out_q   <= 1'b0;
      s2_score_q <= 1'b0;
      s2_norm_q  <= 1'b0;
      s2_out_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      s4_vld_q   <= 1'b0;
      fin_q      <= 1'b0;
    end else begin
      s1_score_q <= cmd_i.score;
      s1_norm_q  <= cmd_i.norm;
      s1_out_q   <= cmd_i.out;
      s2_score_q <= s1_score_q;
      s2_norm_q  <= s1_norm_q;
      s2_out_q   <= s1_out_q;
      s3_vld_q   <= s2_score_q && s2_last_q;
      s4_vld_q   <= s3_vld_q;
      fin_q      <= s2_out_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s1_tail_q  <= cmd_i.tail;
    s1_pos_q   <= pos_i;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_tail_q  <= s1_tail_q;
    s2_pos_q   <= s1_pos_q;
    s3_pos_q   <= s2_pos_q;
    s3_tail_q  <= s2_tail_q;
    s4_pos_q   <= s3_pos_q;
    s4_tail_q  <= s3_tail_q;
  end

  // Distance from the maximum, saturated where the weight is zero anyway
  assign n_w  = N_W'(max_q) - N_W'(w_rd_q);
  assign nsat = (|n_w[N_W-1:NSAT_W]) ? '1 : n_w[NSAT_W-1:0];

  // Multiplier stage
  always_ff @(posedge clk_i) begin
    prod_q  <= q_rd_q * k_rd_q;
    mprod_q <= w_rd_q * v_rd_q;
    m_q     <= nsat * LOG2E_Q16;
  end

  // Look up the exponent weight
  assign exp_i = m_q[M_W-1:32];
  assign exp_f = m_q[31:24];
  assign wexp  = (exp_i >= 6'(EXP_I_MAX)) ? 17'd0 : (EXP_TAB[exp_f] >> exp_i);

  // Accumulate dot products, totals and weighted sums; scale scores, track the maximum
  always_ff @(posedge clk_i) begin
    if (s2_score_q) begin
      dot_q <= s2_first_q ? DOT_W'(prod_q) : dot_q + DOT_W'(prod_q);
    end
    if (s2_norm_q) begin
      total_q <= s2_first_q ? TW'(wexp) : total_q + TW'(wexp);
    end
    if (s2_out_q) begin
      acc_q <= s2_first_q ? ACC_W'(mprod_q) : acc_q + ACC_W'(mprod_q);
    end
    sprod_q <= dot_q * $signed({1'b0, score_scale_i});
    if (s4_vld_q && ((s4_pos_q == '0) || (score > max_q))) begin
      max_q <= score;
    end
  end

  assign score = sprod_q[DOT_W+15:16];

  // Write back scores, then weights
  always_comb begin
    w_we = s4_vld_q || s2_norm_q;
    w_wa = s2_norm_q ? s2_pos_q : s4_pos_q;
    w_wd = s2_norm_q ? $signed(DOT_W'(wexp)) : score;
  end

  // Round and divide one output element
  assign mag       = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign qn        = QN_W'(mag >> 16) + QN_W'(mag[15]);
  assign q_raw     = (qn > QN_W'(131071)) ? '1 : qn[QUO_W-1:0];
  assign div_start = fin_q && norm_mode_i && (total_q != '0);

  gqa_div #(
    .NW   (NUMW),
    .DENW (TW + 1)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ((NUMW'(mag) << 1) + NUMW'(total_q)),
    .den_i   ({total_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= div_done || (fin_q && !div_start);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      fneg_q <= acc_q[ACC_W-1];
      if (!norm_mode_i) begin
        res_val_q <= clamp_q8(acc_q[ACC_W-1], q_raw);
      end else begin
        res_val_q <= '0;
      end
    end else if (div_done) begin
      res_val_q <= clamp_q8(fneg_q, div_quo);
    end
  end

  assign sts_o.score_done = s4_vld_q && s4_tail_q;
  assign sts_o.norm_done  = s2_norm_q && s2_tail_q;
  assign sts_o.elem_done  = res_vld_q;
  assign res_vld_o        = res_vld_q;
  assign res_val_o        = res_val_q;

endmodule

// ===== rtl/gqa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gqa_ctrl
// Sequencer for loads and for the score, weight and output passes of a run.
// ----------------------------------------------------------------------------
module gqa_ctrl import gqa_pkg::*; #(
  parameter int CTX          = 64,
  parameter int NUM_HEADS    = 8,
  parameter int NUM_KV_HEADS = 2,
  parameter int VEC_LEN      = 64,
  parameter int PW           = 6,
  parameter int DW           = 6,
  parameter int KVW          = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     op_i,
  input  logic [5:0]     position_i,
  input  logic [2:0]     head_i,
  input  logic [5:0]     dim_i,
  input  logic           norm_mode_i,
  input  gqa_sts_t       sts_i,
  output gqa_cmd_t       cmd_o,
  output logic           busy_o,
  output logic [2:0]     rhead_o,
  output logic [KVW-1:0] kvh_o,
  output logic [PW-1:0]  pos_o,
  output logic [DW-1:0]  dim_o,
  output logic [5:0]     out_dim_o,
  output logic           last_o
);

  gqa_state_e     state_q, state_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [DW-1:0]  dim_q, dim_d;
  logic [2:0]     rhead_q;
  logic [KVW-1:0] kvh_q;
  logic [KVW-1:0] kvh_lut [8];

  logic accept, head_ok, kv_ok, dim_ok, pos_ok, run_go, p_last, d_last;

  // Map query head to its shared key/value head
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      kvh_lut[i] = KVW'(i * NUM_KV_HEADS / NUM_HEADS);
    end
  end

  assign accept  = start_i && (state_q == S_IDLE);
  assign head_ok = int'(head_i) < NUM_HEADS;
  assign kv_ok   = int'(head_i) < NUM_KV_HEADS;
  assign dim_ok  = int'(dim_i) < VEC_LEN;
  assign pos_ok  = int'(position_i) < CTX;
  assign run_go  = accept && (op_i == OP_RUN) && head_ok;
  assign p_last  = pos_q == PW'(CTX - 1);
  assign d_last  = dim_q == DW'(VEC_LEN - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (run_go) state_d = S_SCORE;
      S_SCORE:   if (p_last && d_last) state_d = S_SCORE_W;
      S_SCORE_W: if (sts_i.score_done) state_d = norm_mode_i ? S_NORM : S_OUT;
      S_NORM:    if (p_last) state_d = S_NORM_W;
      S_NORM_W:  if (sts_i.norm_done) state_d = S_OUT;
      S_OUT:     if (p_last) state_d = S_OUT_W;
      S_OUT_W:   if (sts_i.elem_done) state_d = d_last ? S_IDLE : S_OUT;
      default:   state_d = S_IDLE;
    endcase
  end

  // Advance position and element counters
  always_comb begin
    pos_d = pos_q;
    dim_d = dim_q;
    case (state_q)
      S_SCORE: begin
        if (d_last) begin
          dim_d = '0;
          pos_d = p_last ? '0 : pos_q + PW'(1);
        end else begin
          dim_d = dim_q + DW'(1);
        end
      end
      S_NORM, S_OUT: begin
        pos_d = p_last ? '0 : pos_q + PW'(1);
      end
      S_OUT_W: begin
        if (sts_i.elem_done && !d_last) begin
          dim_d = dim_q + DW'(1);
        end
      end
      default: begin
        pos_d = '0;
        dim_d = '0;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_q = accept && (op_i == OP_WR_Q) && head_ok && dim_ok;
        cmd_o.load_k = accept && (op_i == OP_WR_K) && kv_ok && dim_ok && pos_ok;
        cmd_o.load_v = accept && (op_i == OP_WR_V) && kv_ok && dim_ok && pos_ok;
      end
      S_SCORE: begin
        cmd_o.score = 1'b1;
        cmd_o.first = dim_q == '0;
        cmd_o.last  = d_last;
        cmd_o.tail  = d_last && p_last;
      end
      S_NORM: begin
        cmd_o.norm  = 1'b1;
        cmd_o.first = pos_q == '0;
        cmd_o.last  = p_last;
        cmd_o.tail  = p_last;
      end
      S_OUT: begin
        cmd_o.out   = 1'b1;
        cmd_o.first = pos_q == '0;
        cmd_o.last  = p_last;
        cmd_o.tail  = p_last;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      dim_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      dim_q   <= dim_d;
    end
  end

  // Hold the run's heads
  always_ff @(posedge clk_i) begin
    if (run_go) begin
      rhead_q <= head_i;
      kvh_q   <= kvh_lut[head_i];
    end
  end

  assign busy_o    = state_q != S_IDLE;
  assign rhead_o   = rhead_q;
  assign kvh_o     = kvh_q;
  assign pos_o     = pos_q;
  assign dim_o     = dim_q;
  assign out_dim_o = 6'(dim_q);
  assign last_o    = d_last;

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_q, cmd_o.load_k, cmd_o.load_v, cmd_o.score, cmd_o.norm, cmd_o.out}))
    else $error("more than one datapath command at once");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (op_i == OP_RUN) && head_ok) |=> busy_o)
    else $error("run request not taken");

  a_elem_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.elem_done |-> (state_q == S_OUT_W))
    else $error("output element outside its wait state");

  a_score_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.score_done |-> (state_q == S_SCORE_W))
    else $error("score pass ended outside its wait state");

endmodule

// ===== rtl/gqa_decode_attention_softmax.sv =====
// ----------------------------------------------------------------------------
// gqa_decode_attention_softmax
// Decode-step grouped-query attention in Q8.8 with softmax or raw weights.
// ----------------------------------------------------------------------------
// A load request (write query, key or value) leaves busy_o low, and the next
// request may follow at once. A run request raises busy_o while the block
// walks the context through the multiply-accumulate pipeline on the key and
// value store read ports: dot products for every position, then the pipeline
// drains; with softmax, exponent weights for every position; then for each of
// the VEC_LEN output elements the weighted sum over the context, followed with
// softmax by the bit-serial divider. Results come out one per strobe on
// out_valid_o, each for a single cycle; the receiver cannot hold them off and
// must take every one.
module gqa_decode_attention_softmax import gqa_pkg::*; #(
  parameter int CTX          = 64,
  parameter int NUM_HEADS    = 8,
  parameter int NUM_KV_HEADS = 2,
  parameter int VEC_LEN      = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic [5:0]         position_i,
  input  logic [2:0]         head_i,
  input  logic [5:0]         dim_i,
  input  logic signed [15:0] value_i,
  output logic               out_valid_o,
  output logic signed [15:0] out_value_o,
  output logic [5:0]         out_dim_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PW  = (CTX > 1) ? $clog2(CTX) : 1;
  localparam int DW  = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
  localparam int KVW = (NUM_KV_HEADS > 1) ? $clog2(NUM_KV_HEADS) : 1;

  logic           norm_mode_q;
  logic [15:0]    score_scale_q;
  logic           cfg_we;
  gqa_cmd_t       cmd;
  gqa_sts_t       sts;
  logic [2:0]     rhead;
  logic [KVW-1:0] kvh;
  logic [PW-1:0]  pos;
  logic [DW-1:0]  rdim;
  logic [15:0]    res_val;

  // Configuration registers
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_mode_q   <= 1'b1;
      score_scale_q <= 16'd8192;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_NORM_MODE:   norm_mode_q   <= pwdata[0];
        REG_SCORE_SCALE: score_scale_q <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_SCORE_SCALE) ? {16'd0, score_scale_q}
                                                : {31'd0, norm_mode_q};

  gqa_ctrl #(
    .CTX          (CTX),
    .NUM_HEADS    (NUM_HEADS),
    .NUM_KV_HEADS (NUM_KV_HEADS),
    .VEC_LEN      (VEC_LEN),
    .PW           (PW),
    .DW           (DW),
    .KVW          (KVW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_i),
    .position_i  (position_i),
    .head_i      (head_i),
    .dim_i       (dim_i),
    .norm_mode_i (norm_mode_q),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .rhead_o     (rhead),
    .kvh_o       (kvh),
    .pos_o       (pos),
    .dim_o       (rdim),
    .out_dim_o   (out_dim_o),
    .last_o      (last_o)
  );

  gqa_dpath #(
    .CTX          (CTX),
    .NUM_HEADS    (NUM_HEADS),
    .NUM_KV_HEADS (NUM_KV_HEADS),
    .VEC_LEN      (VEC_LEN),
    .PW           (PW),
    .DW           (DW),
    .KVW          (KVW)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .head_i        (head_i),
    .position_i    (position_i),
    .dim_i         (dim_i),
    .value_i       (value_i),
    .rhead_i       (rhead),
    .kvh_i         (kvh),
    .pos_i         (pos),
    .rdim_i        (rdim),
    .norm_mode_i   (norm_mode_q),
    .score_scale_i (score_scale_q),
    .sts_o         (sts),
    .res_vld_o     (out_valid_o),
    .res_val_o     (res_val)
  );

  assign out_value_o = $signed(res_val);

endmodule

// ===== tb/sv/tb_gqa_decode_attention_softmax.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gqa_decode_attention_softmax
// Self-checking bench for the decode-step attention block. It fills every
// store, walks a table of directed requests, then sends random loads and
// runs. Each accepted run is predicted in the bench and every output element
// is compared in order. Idle gaps are random, and the registers are rewritten
// between runs while the block is idle.
// ----------------------------------------------------------------------------
module tb_gqa_decode_attention_softmax;
  import gqa_pkg::*;

  localparam int CTX_N   = 64;
  localparam int HEADS_N = 8;
  localparam int KV_N    = 2;
  localparam int DIM_N   = 64;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [15:0] value;
    logic [5:0]         dim;
    logic               last;
  } attn_out_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    gqa_op_e            op;
    logic [5:0]         pos;
    logic [2:0]         head;
    logic [5:0]         dim;
    logic signed [15:0] value;
    logic               reg_idx;
    logic [31:0]        reg_val;
    logic               zero_out;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic start_i;
  logic busy_o;
  logic [1:0] op_i;
  logic [5:0] position_i;
  logic [2:0] head_i;
  logic [5:0] dim_i;
  logic signed [15:0] value_i;
  logic out_valid_o;
  logic signed [15:0] out_value_o;
  logic [5:0] out_dim_o;
  logic last_o;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  gqa_decode_attention_softmax dut (.*);

  // Bench copy of block state
  logic signed [15:0] query_mem [HEADS_N*DIM_N];
  logic signed [15:0] key_mem   [CTX_N*KV_N*DIM_N];
  logic signed [15:0] val_mem   [CTX_N*KV_N*DIM_N];
  logic [16:0]        pow2_tab  [256];
  logic               mode_softmax;
  logic [15:0]        scale_q16;

  attn_out_t pending_outputs[$];
  int  fail_count;
  longint cycle_count;
  bit  no_idle;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Compare each output element with the oldest prediction
  always @(posedge clk_i) begin
    attn_out_t e;
    if (rst_ni && out_valid_o) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected output element dim %0d", out_dim_o);
        fail_count++;
      end else begin
        e = pending_outputs.pop_front();
        if (out_value_o !== e.value) begin
          $error("out_value exp %0d got %0d", e.value, out_value_o);
          fail_count++;
        end
        if (out_dim_o !== e.dim) begin
          $error("out_dim exp %0d got %0d", e.dim, out_dim_o);
          fail_count++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Build the 2^(-f/256) table by its Q.32 recurrence
  task automatic build_pow2();
    logic [95:0] a;
    a = 96'd1 << 32;
    for (int f = 0; f < 256; f++) begin
      pow2_tab[f] = 17'((a + 96'd32768) >> 16);
      a = (a * 96'd4283353945 + (96'd1 << 31)) >> 32;
    end
  endtask

  // Work out the output elements of one head
  task automatic predict_attention(input logic [2:0] head, input bit typed_zero);
    longint score [CTX_N];
    longint dot, mx, total, acc, w;
    longint unsigned n, m, ip, mag, q;
    int kvh, kb;
    attn_out_t r;
    kvh = head * KV_N / HEADS_N;
    mx = 0;
    for (int p = 0; p < CTX_N; p++) begin
      dot = 0;
      kb = (p * KV_N + kvh) * DIM_N;
      for (int d = 0; d < DIM_N; d++)
        dot += longint'(query_mem[head*DIM_N + d]) * longint'(key_mem[kb + d]);
      score[p] = (dot * longint'({1'b0, scale_q16})) >>> 16;
      if (p == 0 || score[p] > mx) mx = score[p];
    end
    total = 0;
    if (mode_softmax) begin
      for (int p = 0; p < CTX_N; p++) begin
        n  = longint'(mx - score[p]);
        m  = (n * 64'd94548) >> 16;
        ip = m >> 16;
        w  = (ip >= 17) ? 0 : longint'(pow2_tab[(m >> 8) & 255] >> ip);
        score[p] = w;
        total += w;
      end
    end
    for (int d = 0; d < DIM_N; d++) begin
      acc = 0;
      for (int p = 0; p < CTX_N; p++)
        acc += score[p] * longint'(val_mem[(p * KV_N + kvh) * DIM_N + d]);
      mag = (acc < 0) ? -acc : acc;
      if (mode_softmax)
        q = (total == 0) ? 0 : (2 * mag + total) / (2 * total);
      else
        q = (mag >> 16) + ((mag >> 15) & 1);
      if (acc < 0)
        r.value = (q > 32768) ? -16'sd32768 : -16'(q);
      else
        r.value = (q > 32767) ? 16'sd32767 : 16'(q);
      if (typed_zero) r.value = '0;
      r.dim  = 6'(d);
      r.last = (d == DIM_N - 1);
      pending_outputs.push_back(r);
    end
  endtask

  // Apply an accepted request to the bench state
  task automatic record_request(input gqa_op_e op, input logic [5:0] pos, input logic [2:0] head,
                                input logic [5:0] dim, input logic signed [15:0] v,
                                input bit typed_zero);
    int ix;
    case (op)
      OP_WR_Q: query_mem[head*DIM_N + dim] = v;
      OP_WR_K, OP_WR_V: begin
        if (head < KV_N) begin
          ix = (pos * KV_N + head) * DIM_N + dim;
          if (op == OP_WR_K) key_mem[ix] = v;
          else val_mem[ix] = v;
        end
      end
      default: predict_attention(head, typed_zero);
    endcase
  endtask

  // Send one request, with a random idle gap ahead of it unless no_idle is set
  task automatic send_request(input gqa_op_e op, input logic [5:0] pos, input logic [2:0] head,
                              input logic [5:0] dim, input logic signed [15:0] v,
                              input bit typed_zero);
    while (!no_idle && $urandom_range(99) < 34) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i    <= 1'b1;
    op_i       <= op;
    position_i <= pos;
    head_i     <= head;
    dim_i      <= dim;
    value_i    <= v;
    do @(posedge clk_i); while (busy_o);
    record_request(op, pos, head, dim, v, typed_zero);
    @(negedge clk_i);
  endtask

  // Hold until the block is drained and idle
  task automatic settle();
    start_i <= 1'b0;
    while (pending_outputs.size() != 0 || busy_o) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Write one register over the APB port; caller has settled the block
  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_NORM_MODE) mode_softmax = data[0];
    else scale_q16 = data[15:0];
  endtask

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'd65535;
      2: return 16'd8192;
      default: return 16'($urandom);
    endcase
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    dir_row_t row;
    gqa_op_e op;
    logic [2:0] hd;
    start_i = 1'b0; op_i = '0; position_i = '0; head_i = '0; dim_i = '0; value_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    mode_softmax = 1'b1;
    scale_q16 = 16'd8192;
    build_pow2();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill every store so that no run reads an unwritten entry
    no_idle = 1'b1;
    for (int h = 0; h < HEADS_N; h++)
      for (int d = 0; d < DIM_N; d++)
        send_request(OP_WR_Q, 6'($urandom), 3'(h), 6'(d), 16'($urandom), 0);
    for (int p = 0; p < CTX_N; p++)
      for (int h = 0; h < KV_N; h++)
        for (int d = 0; d < DIM_N; d++) begin
          send_request(OP_WR_K, 6'(p), 3'(h), 6'(d), 16'($urandom), 0);
          send_request(OP_WR_V, 6'(p), 3'(h), 6'(d), 16'($urandom), 0);
        end
    no_idle = 1'b0;

    // Directed table: extremes, ignored writes, every op and both modes
    row = '{ROW_REQ, OP_WR_Q, 6'd0, 3'd0, 6'd0, 16'sh7fff, 1'b0, 32'd0, 1'b0};
    dir_rows.push_back(row);
    row.dim = 6'd63; row.value = 16'sh8000; dir_rows.push_back(row);
    row.op = OP_WR_K; row.pos = 6'd63; row.head = 3'd1; dir_rows.push_back(row);
    row.op = OP_WR_V; row.value = 16'sh7fff; dir_rows.push_back(row);
    row.op = OP_WR_K; row.pos = 6'd0; row.head = 3'd0; row.dim = 6'd0; dir_rows.push_back(row);
    row.op = OP_WR_V; row.value = 16'sh8000; dir_rows.push_back(row);
    row.op = OP_WR_K; row.head = 3'd7; row.value = 16'sh5555; dir_rows.push_back(row);
    row.op = OP_WR_V; row.head = 3'd2; row.value = 16'shaaaa; dir_rows.push_back(row);
    row.op = OP_RUN; row.head = 3'd0; dir_rows.push_back(row);
    row.head = 3'd7; dir_rows.push_back(row);
    row.kind = ROW_CFG; row.reg_idx = REG_NORM_MODE; row.reg_val = 32'd0; dir_rows.push_back(row);
    row.kind = ROW_REQ; row.head = 3'd3; dir_rows.push_back(row);
    row.kind = ROW_CFG; row.reg_idx = REG_SCORE_SCALE; row.reg_val = 32'd0;
    dir_rows.push_back(row);
    // Zero scale in raw mode: every weight is zero, so every output is zero
    row.kind = ROW_REQ; row.head = 3'd5; row.zero_out = 1'b1; dir_rows.push_back(row);
    row.zero_out = 1'b0;
    row.kind = ROW_CFG; row.reg_val = 32'd65535; dir_rows.push_back(row);
    row.kind = ROW_REQ; row.head = 3'd1; dir_rows.push_back(row);
    row.kind = ROW_CFG; row.reg_idx = REG_NORM_MODE; row.reg_val = 32'd1; dir_rows.push_back(row);
    row.kind = ROW_REQ; row.head = 3'd6; dir_rows.push_back(row);
    row.kind = ROW_CFG; row.reg_idx = REG_SCORE_SCALE; row.reg_val = 32'd8192;
    dir_rows.push_back(row);
    row.kind = ROW_REQ; row.head = 3'd4; dir_rows.push_back(row);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_request(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].head, dir_rows[i].dim,
                     dir_rows[i].value, dir_rows[i].zero_out);
      end
    end

    // Random loads and runs, registers changed between runs
    for (int i = 0; i < 350; i++) begin
      no_idle = (i >= 150 && i < 220);
      if (i == 100) settle();
      hd = 3'($urandom);
      if ($urandom_range(99) < 11) begin
        if ($urandom_range(99) < 40) begin
          settle();
          write_reg(REG_NORM_MODE, {31'($urandom), 1'($urandom)});
          write_reg(REG_SCORE_SCALE, {16'($urandom), pick_scale()});
        end
        send_request(OP_RUN, 6'($urandom), hd, 6'($urandom), 16'($urandom), 0);
      end else begin
        op = gqa_op_e'($urandom_range(2));
        if (op != OP_WR_Q && $urandom_range(99) >= 8) hd = 3'($urandom_range(1));
        send_request(op, 6'($urandom), hd, 6'($urandom), 16'($urandom), 0);
      end
    end

    settle();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
